/* hdl/assert_macros.svh */
// Assertion macros shared by the windowed duration statistics RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/wds_pkg.sv */
// Package for windowed duration statistics: controller states, command and status types.
// No dependencies.
package wds_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PASS1,
        ST_DIV_MEAN,
        ST_PASS2,
        ST_DIV_VAR,
        ST_SQRT,
        ST_OUT
    } wds_state_t;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic wr_sample;
        logic scan_start;
        logic scan_step;
        logic div_mean_start;
        logic div_mean_step;
        logic div_var_start;
        logic div_var_step;
        logic sqrt_start;
        logic sqrt_step;
        logic load_out;
        logic load_zero;
    } wds_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic div_last;
        logic sqrt_last;
        logic two_or_more;
        logic one_or_more;
    } wds_stat_t;

endpackage

/* hdl/wds_in_if.sv */
// Input and output channel interfaces: valid/ready handshake with payload.
// No dependencies.
interface wds_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [2:0]  symbol_class;
    logic [31:0] duration;
    modport source (output valid, operation, symbol_class, duration, input ready);
    modport sink (input valid, operation, symbol_class, duration, output ready);
endinterface

interface wds_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  match_count;
    logic [31:0] mean_duration;
    logic [31:0] std_deviation;
    logic        mean_valid;
    logic        deviation_valid;
    modport source (output valid, match_count, mean_duration, std_deviation, mean_valid,
                    deviation_valid, input ready);
    modport sink (input valid, match_count, mean_duration, std_deviation, mean_valid,
                  deviation_valid, output ready);
endinterface

/* hdl/wds_ctrl.sv */
// Controller FSM for windowed duration statistics.
// Depends on wds_pkg.
module wds_ctrl
    import wds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_op,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  wds_stat_t  stat,
    output wds_cmd_t   cmd
);

    wds_state_t state_reg, state_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    logic accept;
    logic free;
    assign free      = !ov_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && free;
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (stat.scan_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept && in_op == OP_QUERY)
                    state_next = ST_PASS1;
            end
            ST_PASS1:
            begin
                if (stat.scan_last)
                    state_next = ST_DIV_MEAN;
            end
            ST_DIV_MEAN:
            begin
                if (stat.div_last)
                    state_next = stat.two_or_more ? ST_PASS2 : ST_OUT;
            end
            ST_PASS2:    if (stat.scan_last) state_next = ST_DIV_VAR;
            ST_DIV_VAR:  if (stat.div_last) state_next = ST_SQRT;
            ST_SQRT:     if (stat.sqrt_last) state_next = ST_OUT;
            ST_OUT:      if (free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Output valid flag
    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (accept && in_op == OP_ADD)
            ov_next = 1'b1;
        if (state_reg == ST_OUT && free)
            ov_next = 1'b1;
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR:    cmd.clr_step = 1'b1;
            ST_IDLE:
            begin
                cmd.wr_sample  = accept && in_op == OP_ADD;
                cmd.load_zero  = accept && in_op == OP_ADD;
                cmd.scan_start = accept && in_op == OP_QUERY;
            end
            ST_PASS1:
            begin
                cmd.scan_step      = 1'b1;
                cmd.div_mean_start = stat.scan_last;
            end
            ST_DIV_MEAN:
            begin
                cmd.div_mean_step = 1'b1;
                cmd.scan_start    = stat.div_last;
            end
            ST_PASS2:
            begin
                cmd.scan_step     = 1'b1;
                cmd.div_var_start = stat.scan_last;
            end
            ST_DIV_VAR:
            begin
                cmd.div_var_step = 1'b1;
                cmd.sqrt_start   = stat.div_last;
            end
            ST_SQRT:     cmd.sqrt_step = 1'b1;
            ST_OUT:      cmd.load_out = free;
            default:     cmd = '0;
        endcase
    end

endmodule

/* hdl/wds_dp.sv */
// Datapath: ring memories, scan accumulators, shared restoring divider, square root.
// Depends on wds_pkg.
module wds_dp
    import wds_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  wds_cmd_t    cmd,
    output wds_stat_t   stat,
    input  logic [2:0]  in_class,
    input  logic [31:0] in_duration,
    output logic [7:0]  match_count,
    output logic [31:0] mean_duration,
    output logic [31:0] std_deviation,
    output logic        mean_valid,
    output logic        deviation_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 32 + CW;
    localparam int QW = 64 + CW;       // quotient width for variance sum

    // Ring storage
    logic [2:0]  class_mem [DEPTH];
    logic [31:0] dur_mem [DEPTH];
    logic [AW-1:0] wp_reg;
    logic [AW:0]   addr_reg;      // scan/clear address, one extra bit to reach DEPTH
    logic          rd_v_reg;
    logic [2:0]    rd_cls_reg;
    logic [31:0]   rd_dur_reg;
    logic          clearing;

    assign clearing = cmd.clr_step;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (clearing && addr_reg < (AW+1)'(DEPTH))
        begin
            class_mem[addr_reg[AW-1:0]] <= 3'd0;
            dur_mem[addr_reg[AW-1:0]]   <= 32'd0;
        end
        else if (cmd.wr_sample)
        begin
            class_mem[wp_reg] <= in_class;
            dur_mem[wp_reg]   <= in_duration;
        end
        rd_cls_reg <= class_mem[addr_reg[AW-1:0]];
        rd_dur_reg <= dur_mem[addr_reg[AW-1:0]];
    end

    logic [2:0]    qcls_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] sum_reg;
    logic [QW-1:0] sq_reg;
    logic [31:0]   mean_reg;
    logic          pass_reg;

    // Scan address and write pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            addr_reg <= '0;
            rd_v_reg <= 1'b0;
            pass_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_sample)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (cmd.scan_start)
            begin
                addr_reg <= '0;
                pass_reg <= cmd.div_mean_step;
            end
            else if ((cmd.scan_step || clearing) && addr_reg < (AW+1)'(DEPTH))
                addr_reg <= addr_reg + 1'b1;
            rd_v_reg <= cmd.scan_step && addr_reg < (AW+1)'(DEPTH);
        end
    end

    assign stat.scan_last = (cmd.scan_step && addr_reg == (AW+1)'(DEPTH) && !rd_v_reg)
                            || (clearing && addr_reg == (AW+1)'(DEPTH - 1));

    // Difference and square, one register each
    logic [31:0] diff_reg;
    logic        dv_reg;
    logic [63:0] sqv_reg;
    logic        sv_reg;
    logic        hit;
    assign hit = rd_v_reg && rd_cls_reg == qcls_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            dv_reg <= hit && pass_reg;
            sv_reg <= dv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= (rd_dur_reg >= mean_reg) ? rd_dur_reg - mean_reg : mean_reg - rd_dur_reg;
        sqv_reg  <= diff_reg * diff_reg;
    end

    // Accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start && !cmd.div_mean_step)
        begin
            qcls_reg <= in_class;
            cnt_reg  <= '0;
            sum_reg  <= '0;
        end
        else if (hit && !pass_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            sum_reg <= sum_reg + SW'(rd_dur_reg);
        end
        if (cmd.scan_start && cmd.div_mean_step)
            sq_reg <= '0;
        else if (sv_reg)
            sq_reg <= sq_reg + QW'(sqv_reg);
    end

    // Pipeline drain: hold the divider and div_last until squares have landed
    logic drain_busy;
    assign drain_busy = rd_v_reg || dv_reg || sv_reg;

    // Shared restoring divider, one quotient bit per cycle unless the scan pipeline drains
    logic [QW-1:0] dq_reg;
    logic [CW:0]   drem_reg;
    logic [CW-1:0] dden_reg;
    logic [6:0]    dcnt_reg;
    logic [CW:0]   dtrial;
    logic [6:0]    dlen;

    assign dtrial = {drem_reg[CW-1:0], dq_reg[QW-1]};
    assign dlen = cmd.div_mean_step ? 7'(SW) : 7'(QW);
    assign stat.div_last = (cmd.div_mean_step || cmd.div_var_step)
                           && dcnt_reg == dlen && !drain_busy;

    always_ff @(posedge clk)
    begin
        if (cmd.div_mean_start)
        begin
            dq_reg   <= QW'(sum_reg) << (QW - SW);
            drem_reg <= '0;
            dden_reg <= (cnt_reg == '0) ? CW'(1) : cnt_reg;
            dcnt_reg <= '0;
        end
        else if (cmd.div_var_start)
        begin
            dq_reg   <= '0;
            drem_reg <= '0;
            dden_reg <= cnt_reg - 1'b1;
            dcnt_reg <= 7'(127);
        end
        else if ((cmd.div_mean_step || cmd.div_var_step) && dcnt_reg != dlen && !drain_busy)
        begin
            if (dcnt_reg == 7'(127))
            begin
                dq_reg   <= sq_reg;
                dcnt_reg <= '0;
            end
            else
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dtrial >= {1'b0, dden_reg})
                begin
                    drem_reg <= dtrial - {1'b0, dden_reg};
                    dq_reg   <= {dq_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dtrial;
                    dq_reg   <= {dq_reg[QW-2:0], 1'b0};
                end
            end
        end
        // Quotient bits of the mean land in the low end after SW shifts
        if (stat.div_last && cmd.div_mean_step)
            mean_reg <= (cnt_reg == '0) ? 32'd0 : dq_reg[31:0];
    end

    // Floor square root, one result bit per cycle
    logic [63:0] sv_val;
    logic [31:0] root_reg;
    logic [65:0] srem_reg;
    logic [63:0] srad_reg;
    logic [5:0]  scnt_reg;
    logic [65:0] strial;
    logic [65:0] stest;

    // Saturate the variance to 64 bits
    assign sv_val = (dq_reg[QW-1:64] != '0) ? {64{1'b1}} : dq_reg[63:0];
    assign strial = {srem_reg[63:0], srad_reg[63:62]};
    assign stest  = {32'd0, root_reg, 2'b01};
    assign stat.sqrt_last = cmd.sqrt_step && scnt_reg == 6'd32;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            srad_reg <= sv_val;
            srem_reg <= '0;
            root_reg <= '0;
            scnt_reg <= '0;
        end
        else if (cmd.sqrt_step && scnt_reg != 6'd32)
        begin
            scnt_reg <= scnt_reg + 1'b1;
            srad_reg <= {srad_reg[61:0], 2'b00};
            if (strial >= stest)
            begin
                srem_reg <= strial - stest;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                srem_reg <= strial;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign stat.two_or_more = cnt_reg >= CW'(2);
    assign stat.one_or_more = cnt_reg != '0;

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_zero)
        begin
            match_count     <= '0;
            mean_duration   <= '0;
            std_deviation   <= '0;
            mean_valid      <= 1'b0;
            deviation_valid <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            match_count     <= 8'(cnt_reg);
            mean_duration   <= mean_reg;
            std_deviation   <= stat.two_or_more ? root_reg : 32'd0;
            mean_valid      <= stat.one_or_more;
            deviation_valid <= stat.two_or_more;
        end
    end

endmodule

/* hdl/windowed_duration_statistics.sv */
// Top level of windowed duration statistics: controller plus datapath.
// Depends on wds_pkg, wds_in_if, wds_out_if, wds_ctrl, wds_dp, assert_macros.svh.
//
//  channel   dir  fields
//  in_ch     in   operation, symbol_class, duration
//  out_ch    out  match_count, mean_duration, std_deviation, mean_valid, deviation_valid
//
// An add writes its sample and returns an all-zero result. A query scans the ring via the
// single memory read port and runs the shared bit-serial divider for the mean; with two or
// more matches it scans again, divides for the variance and takes a 32-step square root.
// After reset a clearing pass zeroes the ring; no item is taken meanwhile.
// A result waits in the output register; the next item is taken once it is drained.
`include "assert_macros.svh"
module windowed_duration_statistics
    import wds_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input logic clk,
    input logic rst_n,
    wds_in_if.sink    in_ch,
    wds_out_if.source out_ch
);

    wds_cmd_t  cmd;
    wds_stat_t stat;

    wds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_op     (in_ch.operation),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wds_dp #(.DEPTH(DEPTH)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_class        (in_ch.symbol_class),
        .in_duration     (in_ch.duration),
        .match_count     (out_ch.match_count),
        .mean_duration   (out_ch.mean_duration),
        .std_deviation   (out_ch.std_deviation),
        .mean_valid      (out_ch.mean_valid),
        .deviation_valid (out_ch.deviation_valid)
    );

    `ASSERT_IMPL(a_dev_implies_mean, clk, rst_n, out_ch.valid && out_ch.deviation_valid, out_ch.mean_valid)
    `ASSERT_IMPL(a_no_write_in_scan, clk, rst_n, cmd.scan_step, !cmd.wr_sample)
    `ASSERT_NEXT(a_add_gives_result, clk, rst_n, cmd.wr_sample, out_ch.valid)

endmodule
